[rtl/mxt_pkg.sv]
package mxt_pkg;

  localparam int KEY_BITS   = 31;
  localparam int NODE_BITS  = 16;
  localparam int NODE_SLOTS = 1 << NODE_BITS;
  localparam int COUNT_BITS = 20;
  localparam int ALLOC_BITS = NODE_BITS + 1;
  localparam int LVL_BITS   = $clog2(KEY_BITS + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_CHECK,
    S_INS_UPD,
    S_REM_SCAN,
    S_REM_UPD,
    S_QRY_NODE,
    S_QRY_PROBE,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [NODE_BITS-1:0]  left;
    logic [NODE_BITS-1:0]  right;
    logic [1:0]            valid;
    logic [COUNT_BITS-1:0] count;
  } node_t;

  typedef struct packed {
    logic                 rd_en;
    logic [NODE_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [NODE_BITS-1:0] wr_addr;
    node_t                wr_data;
  } mem_req_t;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] best_xor;
    status_e             status;
  } res_t;

endpackage

[rtl/mxt_req_if.sv]
interface mxt_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   op;
  logic [mxt_pkg::KEY_BITS-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink (input valid, input op, input key, output ready);
endinterface

[rtl/mxt_rsp_if.sv]
interface mxt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [mxt_pkg::KEY_BITS-1:0] best_xor;
  logic [1:0]                   status;

  modport source (output valid, output best_xor, output status, input ready);
  modport sink (input valid, input best_xor, input status, output ready);
endinterface

[rtl/mxt_node_mem.sv]
module mxt_node_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mxt_pkg::mem_req_t req_i,
  output mxt_pkg::node_t    rd_data_o
);

  mxt_pkg::node_t node_mem_q [mxt_pkg::NODE_SLOTS];
  mxt_pkg::node_t rd_q;
  logic           root_wr_q;
  logic           rd_zero_q;

  // Read data is held until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      node_mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= node_mem_q[req_i.rd_addr];
    end
  end

  // The root reads as an empty node until it is first written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_wr_q <= 1'b0;
      rd_zero_q <= 1'b0;
    end else begin
      if (req_i.wr_en && (req_i.wr_addr == '0)) begin
        root_wr_q <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_zero_q <= (req_i.rd_addr == '0) && !root_wr_q;
      end
    end
  end

  assign rd_data_o = rd_zero_q ? '0 : rd_q;

endmodule

[rtl/mxt_walker.sv]
module mxt_walker (
  input  logic              clk_i,
  input  logic              rst_ni,
  mxt_req_if.sink           req_i,
  input  logic              res_free_i,
  output mxt_pkg::res_t     res_o,
  output mxt_pkg::mem_req_t mem_req_o,
  input  mxt_pkg::node_t    rd_data_i
);

  localparam int KB = mxt_pkg::KEY_BITS;
  localparam int NB = mxt_pkg::NODE_BITS;
  localparam int AB = mxt_pkg::ALLOC_BITS;
  localparam int LB = mxt_pkg::LVL_BITS;
  localparam int CB = mxt_pkg::COUNT_BITS;

  mxt_pkg::state_e  state_q, state_d;
  mxt_pkg::op_e     op_q, op_d;
  mxt_pkg::status_e status_q, status_d;
  logic [KB-1:0]    key_q, key_d;
  logic [KB-1:0]    sh_q, sh_d;
  logic [KB-1:0]    acc_q, acc_d;
  logic [LB-1:0]    lvl_q, lvl_d;
  logic [LB-1:0]    need_q, need_d;
  logic [NB-1:0]    node_q, node_d;
  logic [AB-1:0]    alloc_q, alloc_d;
  logic [CB-1:0]    root_cnt_q, root_cnt_d;
  mxt_pkg::node_t   ent_q, ent_d;
  logic             fresh_q, fresh_d;

  mxt_pkg::node_t   cur;
  mxt_pkg::node_t   wr_node;
  logic             bit_w;
  logic             at_leaf;
  logic             child_ok;
  logic [NB-1:0]    child_ptr;
  logic             want_ok;
  logic [NB-1:0]    want_ptr;
  logic [NB-1:0]    fall_ptr;
  logic [NB-1:0]    want_prev_ptr;
  logic [CB-1:0]    cnt_adj;
  logic [AB:0]      pool_sum;
  logic             ins_fail;
  logic             root_empty;
  mxt_pkg::op_e     req_op;

  // A freshly allocated node has never been written; it is known to be empty.
  assign cur       = fresh_q ? '0 : rd_data_i;
  assign bit_w     = sh_q[KB-1];
  assign at_leaf   = (lvl_q == LB'(KB));
  assign child_ok  = cur.valid[bit_w];
  assign child_ptr = bit_w ? cur.right : cur.left;
  assign want_ok   = cur.valid[!bit_w];
  assign want_ptr  = bit_w ? cur.left : cur.right;
  assign fall_ptr  = bit_w ? ent_q.right : ent_q.left;
  assign want_prev_ptr = bit_w ? ent_q.left : ent_q.right;
  assign req_op    = mxt_pkg::op_e'(req_i.op);
  assign root_empty = (lvl_q == '0) && (cur.count == '0);

  // Shared count unit: one increment or decrement per visited node.
  assign cnt_adj = (op_q == mxt_pkg::OP_REMOVE) ? (cur.count - CB'(1)) : (cur.count + CB'(1));

  assign pool_sum = (AB + 1)'(alloc_q) + (AB + 1)'(need_q);
  assign ins_fail = (pool_sum > (AB + 1)'(mxt_pkg::NODE_SLOTS)) || (root_cnt_q == '1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mxt_pkg::S_IDLE: begin
        if (req_i.valid) begin
          case (req_op)
            mxt_pkg::OP_INSERT: state_d = mxt_pkg::S_INS_SCAN;
            mxt_pkg::OP_REMOVE: state_d = mxt_pkg::S_REM_SCAN;
            mxt_pkg::OP_QUERY:  state_d = mxt_pkg::S_QRY_NODE;
            default:            state_d = mxt_pkg::S_FIN;
          endcase
        end
      end
      mxt_pkg::S_INS_SCAN: begin
        if (at_leaf || !child_ok) state_d = mxt_pkg::S_INS_CHECK;
      end
      mxt_pkg::S_INS_CHECK: begin
        state_d = ins_fail ? mxt_pkg::S_FIN : mxt_pkg::S_INS_UPD;
      end
      mxt_pkg::S_INS_UPD: begin
        if (at_leaf) state_d = mxt_pkg::S_FIN;
      end
      mxt_pkg::S_REM_SCAN: begin
        if (at_leaf) begin
          state_d = (cur.count == '0) ? mxt_pkg::S_FIN : mxt_pkg::S_REM_UPD;
        end else if (!child_ok) begin
          state_d = mxt_pkg::S_FIN;
        end
      end
      mxt_pkg::S_REM_UPD: begin
        if (at_leaf) state_d = mxt_pkg::S_FIN;
      end
      mxt_pkg::S_QRY_NODE: begin
        if (root_empty || at_leaf) begin
          state_d = mxt_pkg::S_FIN;
        end else if (want_ok) begin
          state_d = mxt_pkg::S_QRY_PROBE;
        end
      end
      mxt_pkg::S_QRY_PROBE: begin
        state_d = mxt_pkg::S_QRY_NODE;
      end
      mxt_pkg::S_FIN: begin
        if (res_free_i) state_d = mxt_pkg::S_IDLE;
      end
      default: state_d = mxt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_d       = op_q;
    status_d   = status_q;
    key_d      = key_q;
    sh_d       = sh_q;
    acc_d      = acc_q;
    lvl_d      = lvl_q;
    need_d     = need_q;
    node_d     = node_q;
    alloc_d    = alloc_q;
    root_cnt_d = root_cnt_q;
    ent_d      = ent_q;
    fresh_d    = fresh_q;
    mem_req_o  = '0;
    wr_node    = cur;
    req_i.ready = 1'b0;
    res_o.valid    = 1'b0;
    res_o.best_xor = acc_q;
    res_o.status   = status_q;

    case (state_q)
      mxt_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          op_d     = req_op;
          key_d    = req_i.key;
          sh_d     = req_i.key;
          acc_d    = '0;
          lvl_d    = '0;
          node_d   = '0;
          fresh_d  = 1'b0;
          status_d = mxt_pkg::ST_OK;
          if (req_op != mxt_pkg::OP_NONE) begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = '0;
          end
        end
      end
      mxt_pkg::S_INS_SCAN: begin
        if (lvl_q == '0) root_cnt_d = cur.count;
        if (at_leaf || !child_ok) begin
          need_d = LB'(KB) - lvl_q;
        end else begin
          node_d = child_ptr;
          lvl_d  = lvl_q + LB'(1);
          sh_d   = {sh_q[KB-2:0], 1'b0};
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = child_ptr;
        end
      end
      mxt_pkg::S_INS_CHECK: begin
        if (ins_fail) begin
          status_d = mxt_pkg::ST_FULL;
        end else begin
          node_d  = '0;
          lvl_d   = '0;
          sh_d    = key_q;
          fresh_d = 1'b0;
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = '0;
        end
      end
      mxt_pkg::S_INS_UPD: begin
        wr_node.count = cnt_adj;
        if (!at_leaf) begin
          lvl_d = lvl_q + LB'(1);
          sh_d  = {sh_q[KB-2:0], 1'b0};
          if (child_ok) begin
            node_d = child_ptr;
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = child_ptr;
          end else begin
            // Once a node is missing, every node below it on the path is new.
            if (bit_w) begin
              wr_node.right = alloc_q[NB-1:0];
            end else begin
              wr_node.left = alloc_q[NB-1:0];
            end
            wr_node.valid[bit_w] = 1'b1;
            node_d  = alloc_q[NB-1:0];
            alloc_d = alloc_q + AB'(1);
            fresh_d = 1'b1;
          end
        end
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = node_q;
        mem_req_o.wr_data = wr_node;
      end
      mxt_pkg::S_REM_SCAN: begin
        if (at_leaf) begin
          if (cur.count == '0) begin
            status_d = mxt_pkg::ST_ABSENT;
          end else begin
            node_d = '0;
            lvl_d  = '0;
            sh_d   = key_q;
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = '0;
          end
        end else if (!child_ok) begin
          status_d = mxt_pkg::ST_ABSENT;
        end else begin
          node_d = child_ptr;
          lvl_d  = lvl_q + LB'(1);
          sh_d   = {sh_q[KB-2:0], 1'b0};
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = child_ptr;
        end
      end
      mxt_pkg::S_REM_UPD: begin
        wr_node.count     = cnt_adj;
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = node_q;
        mem_req_o.wr_data = wr_node;
        if (!at_leaf) begin
          node_d = child_ptr;
          lvl_d  = lvl_q + LB'(1);
          sh_d   = {sh_q[KB-2:0], 1'b0};
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = child_ptr;
        end
      end
      mxt_pkg::S_QRY_NODE: begin
        if (root_empty) begin
          status_d = mxt_pkg::ST_EMPTY;
        end else if (!at_leaf) begin
          ent_d = cur;
          if (want_ok) begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = want_ptr;
          end else begin
            node_d = child_ptr;
            acc_d  = {acc_q[KB-2:0], 1'b0};
            lvl_d  = lvl_q + LB'(1);
            sh_d   = {sh_q[KB-2:0], 1'b0};
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = child_ptr;
          end
        end
      end
      mxt_pkg::S_QRY_PROBE: begin
        lvl_d = lvl_q + LB'(1);
        sh_d  = {sh_q[KB-2:0], 1'b0};
        if (cur.count != '0) begin
          // The probed child is the next node and its entry is already read.
          node_d = want_prev_ptr;
          acc_d  = {acc_q[KB-2:0], 1'b1};
        end else begin
          node_d = fall_ptr;
          acc_d  = {acc_q[KB-2:0], 1'b0};
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = fall_ptr;
        end
      end
      mxt_pkg::S_FIN: begin
        res_o.valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mxt_pkg::S_IDLE;
      alloc_q <= AB'(1);
      fresh_q <= 1'b0;
    end else begin
      state_q <= state_d;
      alloc_q <= alloc_d;
      fresh_q <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    status_q   <= status_d;
    key_q      <= key_d;
    sh_q       <= sh_d;
    acc_q      <= acc_d;
    lvl_q      <= lvl_d;
    need_q     <= need_d;
    node_q     <= node_d;
    root_cnt_q <= root_cnt_d;
    ent_q      <= ent_d;
  end

  a_alloc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_q <= AB'(mxt_pkg::NODE_SLOTS))
    else $error("node allocator ran past the pool");

  a_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req_o.wr_en && mem_req_o.rd_en) |-> (mem_req_o.wr_addr != mem_req_o.rd_addr))
    else $error("node read and write collide on one address");

  a_alloc_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (alloc_q != $past(alloc_q)) |-> ($past(state_q) == mxt_pkg::S_INS_UPD))
    else $error("allocator moved outside an insert update");

  a_lvl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mxt_pkg::S_IDLE) |-> (lvl_q <= LB'(KB)))
    else $error("walk level beyond the leaf");

endmodule

[rtl/max_xor_binary_trie.sv]
// Channel | Dir | Payload            | Transfer
// req_i   | in  | op, key            | valid && ready
// rsp_o   | out | best_xor, status   | valid && ready
//
// An insert walks the key path once to scan it and once to update the counts, as does
// a remove, and a query walks it once, probing the opposite branch where it exists;
// each key bit costs one or two dependent reads of the node memory.
// Every result then passes through the finish state before it is registered.
// Reset is asynchronous and active low; the trie starts empty with no clearing pass.
// A finished result sits in an output register, so a stalled rsp_o does not
// keep req_i from accepting the next request once the walker is idle.
module max_xor_binary_trie (
  input  logic     clk_i,
  input  logic     rst_ni,
  mxt_req_if.sink  req_i,
  mxt_rsp_if.source rsp_o
);

  mxt_pkg::mem_req_t mem_req;
  mxt_pkg::node_t    rd_data;
  mxt_pkg::res_t     res;
  logic              res_free;
  logic              out_valid_q;
  logic [mxt_pkg::KEY_BITS-1:0] best_q;
  mxt_pkg::status_e  status_q;

  assign res_free = !out_valid_q || rsp_o.ready;

  mxt_walker u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .res_free_i (res_free),
    .res_o      (res),
    .mem_req_o  (mem_req),
    .rd_data_i  (rd_data)
  );

  mxt_node_mem u_node_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && res.valid) begin
      best_q   <= res.best_xor;
      status_q <= res.status;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.best_xor = best_q;
  assign rsp_o.status   = status_q;

endmodule

[verif/max_xor_binary_trie_test.sv]
module max_xor_binary_trie_test;

  localparam int KEY_BITS      = mxt_pkg::KEY_BITS;
  localparam int NODE_BITS     = mxt_pkg::NODE_BITS;
  localparam int NODE_SLOTS    = mxt_pkg::NODE_SLOTS;
  localparam int COUNT_BITS    = mxt_pkg::COUNT_BITS;
  localparam int CYCLE_LIMIT   = 600_000;
  localparam int RANDOM_ITEMS  = 680;
  localparam int TAIL_ITEMS    = 200;
  localparam int TAIL_CYCLES   = 150;
  localparam logic [KEY_BITS-1:0] KEY_ONES = '1;

  typedef struct packed {
    logic [KEY_BITS-1:0] best_xor;
    mxt_pkg::status_e    status;
  } answer_t;

  logic clk;
  logic rst_n;

  mxt_req_if req_if ();
  mxt_rsp_if rsp_if ();

  max_xor_binary_trie i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the trie.
  bit [NODE_BITS-1:0]  trie_left  [NODE_SLOTS];
  bit [NODE_BITS-1:0]  trie_right [NODE_SLOTS];
  bit [1:0]            trie_valid [NODE_SLOTS];
  bit [COUNT_BITS-1:0] trie_count [NODE_SLOTS];
  int unsigned         trie_next_free;

  answer_t             pending_answers[$];
  logic [KEY_BITS-1:0] stored_keys[$];
  mxt_pkg::status_e    last_predicted;

  int unsigned cycle_count;
  int          error_count;
  int          stall_left;
  bit          req_idle_en;
  bit          rsp_stall_en;
  int          op_seen     [4];
  int          status_seen [4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_answers.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned child_at(int unsigned node, bit side);
    return side ? trie_right[node] : trie_left[node];
  endfunction

  function automatic mxt_pkg::status_e trie_insert(logic [KEY_BITS-1:0] key);
    int unsigned node;
    int unsigned fresh;
    int unsigned missing;
    bit          present;
    bit          side;
    node    = 0;
    missing = 0;
    present = 1'b1;
    for (int lvl = 0; lvl < KEY_BITS; lvl++) begin
      if (present) begin
        side    = key[KEY_BITS-1-lvl];
        present = trie_valid[node][side];
        if (present) node = child_at(node, side);
      end
      if (!present) missing++;
    end
    if (trie_next_free + missing > NODE_SLOTS) return mxt_pkg::ST_FULL;
    if (trie_count[0] == '1) return mxt_pkg::ST_FULL;
    node = 0;
    for (int lvl = 0; lvl < KEY_BITS; lvl++) begin
      side = key[KEY_BITS-1-lvl];
      trie_count[node]++;
      if (!trie_valid[node][side]) begin
        fresh = trie_next_free % NODE_SLOTS;
        trie_next_free++;
        trie_left[fresh]  = '0;
        trie_right[fresh] = '0;
        trie_valid[fresh] = '0;
        trie_count[fresh] = '0;
        if (side) trie_right[node] = fresh[NODE_BITS-1:0];
        else trie_left[node] = fresh[NODE_BITS-1:0];
        trie_valid[node][side] = 1'b1;
        node = fresh;
      end else begin
        node = child_at(node, side);
      end
    end
    trie_count[node]++;
    return mxt_pkg::ST_OK;
  endfunction

  function automatic mxt_pkg::status_e trie_remove(logic [KEY_BITS-1:0] key);
    int unsigned node;
    bit          side;
    node = 0;
    for (int lvl = 0; lvl < KEY_BITS; lvl++) begin
      side = key[KEY_BITS-1-lvl];
      if (!trie_valid[node][side]) return mxt_pkg::ST_ABSENT;
      node = child_at(node, side);
    end
    if (trie_count[node] == 0) return mxt_pkg::ST_ABSENT;
    node = 0;
    for (int lvl = 0; lvl < KEY_BITS; lvl++) begin
      trie_count[node]--;
      node = child_at(node, key[KEY_BITS-1-lvl]);
    end
    trie_count[node]--;
    return mxt_pkg::ST_OK;
  endfunction

  function automatic answer_t trie_best_xor(logic [KEY_BITS-1:0] key);
    answer_t     ans;
    int unsigned node;
    bit          want;
    ans.best_xor = '0;
    ans.status   = mxt_pkg::ST_OK;
    node         = 0;
    if (trie_count[0] == 0) begin
      ans.status = mxt_pkg::ST_EMPTY;
      return ans;
    end
    for (int lvl = 0; lvl < KEY_BITS; lvl++) begin
      want = ~key[KEY_BITS-1-lvl];
      ans.best_xor = ans.best_xor << 1;
      // Take the opposite branch whenever it still holds keys.
      if (trie_valid[node][want] && trie_count[child_at(node, want)] != 0) begin
        ans.best_xor[0] = 1'b1;
        node = child_at(node, want);
      end else begin
        node = child_at(node, ~want);
      end
    end
    return ans;
  endfunction

  function automatic answer_t trie_apply(mxt_pkg::op_e op, logic [KEY_BITS-1:0] key);
    answer_t ans;
    ans.best_xor = '0;
    ans.status   = mxt_pkg::ST_OK;
    case (op)
      mxt_pkg::OP_INSERT: ans.status = trie_insert(key);
      mxt_pkg::OP_REMOVE: ans.status = trie_remove(key);
      mxt_pkg::OP_QUERY:  ans = trie_best_xor(key);
      default:            ans.status = mxt_pkg::ST_OK;
    endcase
    return ans;
  endfunction

  task automatic report_mismatch(string field, logic [KEY_BITS-1:0] got,
                                 logic [KEY_BITS-1:0] want);
    error_count++;
    $display("Mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h", cycle_count, field,
             got, want);
  endtask

  // Response checker: every transfer on rsp is matched against the oldest prediction.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected response, status", KEY_BITS'(rsp_if.status), '0);
      end else begin
        want = pending_answers.pop_front();
        status_seen[rsp_if.status]++;
        if (rsp_if.status !== want.status)
          report_mismatch("status", KEY_BITS'(rsp_if.status), KEY_BITS'(want.status));
        if (rsp_if.best_xor !== want.best_xor)
          report_mismatch("best_xor", rsp_if.best_xor, want.best_xor);
      end
    end
  end

  // Response ready with random stall bursts.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (rst_n && rsp_stall_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 7);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= rst_n;
      end
    end
  end

  // Valid stays high after a transfer; the next call either replaces the payload
  // at the following falling edge or drops valid for an idle burst.
  task automatic send_request(mxt_pkg::op_e op, logic [KEY_BITS-1:0] key);
    answer_t ans;
    @(negedge clk);
    if (req_idle_en && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.key   <= key;
    do @(posedge clk); while (!req_if.ready);
    ans = trie_apply(op, key);
    last_predicted = ans.status;
    op_seen[op]++;
    pending_answers = {pending_answers, ans};
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [KEY_BITS-1:0] random_key();
    return KEY_BITS'($urandom);
  endfunction

  function automatic logic [KEY_BITS-1:0] key_near(logic [KEY_BITS-1:0] base);
    logic [KEY_BITS-1:0] mask;
    mask = (KEY_BITS'(1) << $urandom_range(1, 12)) - KEY_BITS'(1);
    return base ^ (random_key() & mask);
  endfunction

  function automatic logic [KEY_BITS-1:0] some_stored_key();
    if (stored_keys.size() == 0) return random_key();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  task automatic test_directed();
    // Empty trie: query reports empty, remove reports absent.
    send_request(mxt_pkg::OP_QUERY, KEY_ONES);
    send_request(mxt_pkg::OP_REMOVE, '0);
    send_request(mxt_pkg::OP_NONE, random_key());
    send_request(mxt_pkg::OP_INSERT, '0);
    send_request(mxt_pkg::OP_INSERT, KEY_ONES);
    send_request(mxt_pkg::OP_QUERY, '0);
    send_request(mxt_pkg::OP_QUERY, KEY_ONES);
    // The set is a multiset, so a second copy needs a second remove.
    send_request(mxt_pkg::OP_INSERT, '0);
    send_request(mxt_pkg::OP_REMOVE, '0);
    send_request(mxt_pkg::OP_QUERY, KEY_ONES);
    send_request(mxt_pkg::OP_REMOVE, '0);
    // Path exists but the leaf count is zero.
    send_request(mxt_pkg::OP_REMOVE, '0);
    send_request(mxt_pkg::OP_QUERY, KEY_ONES);
    // Path breaks off below the root.
    send_request(mxt_pkg::OP_REMOVE, 31'h4000_0000);
    send_request(mxt_pkg::OP_INSERT, 31'h5555_5555);
    send_request(mxt_pkg::OP_INSERT, 31'h2AAA_AAAA);
    send_request(mxt_pkg::OP_QUERY, 31'h5555_5555);
    send_request(mxt_pkg::OP_QUERY, 31'h1234_5678);
    send_request(mxt_pkg::OP_NONE, KEY_ONES);
    send_request(mxt_pkg::OP_REMOVE, KEY_ONES);
    send_request(mxt_pkg::OP_REMOVE, 31'h2AAA_AAAA);
    send_request(mxt_pkg::OP_REMOVE, 31'h5555_5555);
    // Nodes remain allocated but every count is zero.
    send_request(mxt_pkg::OP_QUERY, '0);
    send_request(mxt_pkg::OP_INSERT, 31'h0000_0001);
    send_request(mxt_pkg::OP_QUERY, 31'h0000_0001);
    stored_keys = {stored_keys, 31'h0000_0001};
    wait_drained();
  endtask

  task automatic test_random_mix();
    int                  pick;
    int                  idx;
    logic [KEY_BITS-1:0] key;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      req_idle_en  = ((i / 100) % 3) != 2;
      rsp_stall_en = ((i / 100) % 3) != 2;
      if (i == RANDOM_ITEMS / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) key = random_key();
        else if (pick < 7) key = key_near(some_stored_key());
        else key = some_stored_key();
        send_request(mxt_pkg::OP_INSERT, key);
        if (last_predicted == mxt_pkg::ST_OK) stored_keys = {stored_keys, key};
      end else if (pick < 60) begin
        if (stored_keys.size() != 0 && $urandom_range(0, 4) != 0) begin
          idx = $urandom_range(0, stored_keys.size() - 1);
          send_request(mxt_pkg::OP_REMOVE, stored_keys[idx]);
          if (last_predicted == mxt_pkg::ST_OK) stored_keys.delete(idx);
        end else begin
          send_request(mxt_pkg::OP_REMOVE, $urandom_range(0, 1) ? random_key()
                                                       : key_near(some_stored_key()));
        end
      end else if (pick < 95) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) key = random_key();
        else if (pick < 8) key = key_near(some_stored_key());
        else key = some_stored_key();
        send_request(mxt_pkg::OP_QUERY, key);
      end else begin
        send_request(mxt_pkg::OP_NONE, random_key());
      end
    end
    wait_drained();
  endtask

  // Keep working on the populated trie with no idling from here to the end.
  task automatic test_no_idle();
    int                  idx;
    logic [KEY_BITS-1:0] key;
    req_idle_en  = 1'b0;
    rsp_stall_en = 1'b0;
    for (int i = 0; i < TAIL_ITEMS; i++) begin
      case ($urandom_range(0, 4))
        0, 1: begin
          key = ($urandom_range(0, 1) != 0) ? some_stored_key() : random_key();
          send_request(mxt_pkg::OP_INSERT, key);
          if (last_predicted == mxt_pkg::ST_OK) stored_keys = {stored_keys, key};
        end
        2: begin
          if (stored_keys.size() != 0) begin
            idx = $urandom_range(0, stored_keys.size() - 1);
            send_request(mxt_pkg::OP_REMOVE, stored_keys[idx]);
            if (last_predicted == mxt_pkg::ST_OK) stored_keys.delete(idx);
          end else begin
            send_request(mxt_pkg::OP_REMOVE, random_key());
          end
        end
        3: send_request(mxt_pkg::OP_QUERY, random_key());
        default: send_request(mxt_pkg::OP_NONE, random_key());
      endcase
    end
    wait_drained();
  endtask

  initial begin
    req_if.valid   = 1'b0;
    req_if.op      = '0;
    req_if.key     = '0;
    rst_n          = 1'b0;
    trie_next_free = 1;
    req_idle_en    = 1'b1;
    rsp_stall_en   = 1'b1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_mix();
    test_no_idle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_answers.size() != 0)
      report_mismatch("results never returned, count", KEY_BITS'(pending_answers.size()), '0);
    $display("Covered %0d inserts, %0d removes, %0d queries, %0d unused ops; %0d nodes used.",
             op_seen[mxt_pkg::OP_INSERT], op_seen[mxt_pkg::OP_REMOVE],
             op_seen[mxt_pkg::OP_QUERY], op_seen[mxt_pkg::OP_NONE], trie_next_free);
    $display("Statuses seen: ok %0d, empty %0d, absent %0d, full %0d; %0d mismatches.",
             status_seen[mxt_pkg::ST_OK], status_seen[mxt_pkg::ST_EMPTY],
             status_seen[mxt_pkg::ST_ABSENT], status_seen[mxt_pkg::ST_FULL], error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
